### hdl/tlc_pkg.sv
// Package of the two-road traffic light controller.
// Holds the payload types, register indexes, reset values and the segment decoder.
// No dependencies.
package tlc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND = 2'd0,
    CFG_CYCLE_TOP        = 2'd1,
    CFG_SWITCH_POINT     = 2'd2,
    CFG_YELLOW_LENGTH    = 2'd3
  } cfg_idx_e;

  // Request kinds carried by an input item
  localparam logic REQ_TIME_TICK = 1'b0;
  localparam logic REQ_SCAN_TICK = 1'b1;

  // Register reset values
  localparam logic [7:0] TPS_RESET    = 8'd20;
  localparam logic [6:0] TOP_RESET    = 7'd61;
  localparam logic [6:0] SWITCH_RESET = 7'd30;
  localparam logic [6:0] YELLOW_RESET = 7'd3;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [6:0] SHOW_MAX  = 7'd99;

  // Active-low seven-segment codes for 0..9
  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // One result item
  typedef struct packed {
    logic       red_one;
    logic       yellow_one;
    logic       green_one;
    logic       red_two;
    logic       yellow_two;
    logic       green_two;
    logic [3:0] digit_enable;
    logic [7:0] segment_pattern;
  } tlc_out_t;

  // Segment code of the tens or units digit of v, clamped to 99.
  // Tens come from v*103 >> 10, exact for v below 179.
  function automatic logic [7:0] seg_of(input logic [6:0] v, input logic tens);
    logic [6:0]  c;
    logic [13:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    c = (v > SHOW_MAX) ? SHOW_MAX : v;
    p = 14'(c) * 14'd103;
    q = p[13:10];
    r = c - 7'(q) * 7'd10;
    return tens ? SEG_CODE[q] : SEG_CODE[r[3:0]];
  endfunction

endpackage

### hdl/tlc_if.sv
// Handshake channels of the traffic light controller: input items and result items.
// Depends on nothing; payload widths follow the item fields.
interface tlc_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic manual_mode;
  logic manual_direction;

  modport source (output valid, req_type, manual_mode, manual_direction, input ready);
  modport sink   (input valid, req_type, manual_mode, manual_direction, output ready);
endinterface

interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic       red_one;
  logic       yellow_one;
  logic       green_one;
  logic       red_two;
  logic       yellow_two;
  logic       green_two;
  logic [3:0] digit_enable;
  logic [7:0] segment_pattern;

  modport source (output valid, red_one, yellow_one, green_one, red_two, yellow_two,
                  green_two, digit_enable, segment_pattern, input ready);
  modport sink   (input valid, red_one, yellow_one, green_one, red_two, yellow_two,
                  green_two, digit_enable, segment_pattern, output ready);
endinterface

### hdl/traffic_light_countdown_controller.sv
// Top level of the two-road traffic light controller with countdown display.
// Depends on tlc_pkg and the channel interfaces in tlc_if.sv.
//
// Usage: every input item is either a base time tick or a display scan tick.
// Time ticks are divided by ticks_per_second into seconds; the seconds
// countdown runs from cycle_top down to 0 and reloads. The countdown picks
// the lamp phase; each road shows its remaining seconds on two active-low
// seven-segment digits, one digit per scan tick. Manual mode drives lamps
// from manual_direction and blanks the digits while the counters keep going.
// Every input item yields exactly one result item.
// A result item passes the input snapshot register, then the result register.
// Throughput: one item per cycle while the receiver takes results, set by the
// counter update at the input register. Reset clears the counters (countdown
// to 61), loads register defaults and empties both stages. When the receiver
// stalls, the result register holds, the snapshot stage fills, and then ready
// drops until the receiver moves. Configuration writes take effect at the write
// edge; the user must make them while idle, as the block does not enforce it.
module traffic_light_countdown_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  tlc_in_if.sink           in_if,
  tlc_out_if.source        out_if
);

  // Configuration registers
  logic [7:0] tps_q;
  logic [6:0] top_q, switch_q, yellow_q;

  // Counter state
  logic [7:0] tick_q, tick_d;
  logic [6:0] secs_q, secs_d;
  logic [1:0] scan_q, scan_d;

  // Snapshot stage
  logic       s1_valid_q;
  logic       s1_manual_q, s1_dir_q, s1_scan_req_q;
  logic [6:0] s1_secs_q;
  logic [1:0] s1_scan_q;

  // Result stage
  logic               out_valid_q;
  tlc_pkg::tlc_out_t  out_q, out_d;

  logic out_free, s1_adv, in_fire;
  logic [7:0] tick_inc;

  // Handshake control
  assign out_free = !out_valid_q || out_if.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || out_free;
  assign in_fire  = in_if.valid && in_if.ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= tlc_pkg::TPS_RESET;
      top_q    <= tlc_pkg::TOP_RESET;
      switch_q <= tlc_pkg::SWITCH_RESET;
      yellow_q <= tlc_pkg::YELLOW_RESET;
    end else if (cfg_we_i) begin
      case (tlc_pkg::cfg_idx_e'(cfg_idx_i))
        tlc_pkg::CFG_TICKS_PER_SECOND: tps_q    <= cfg_data_i;
        tlc_pkg::CFG_CYCLE_TOP:        top_q    <= cfg_data_i[6:0];
        tlc_pkg::CFG_SWITCH_POINT:     switch_q <= cfg_data_i[6:0];
        tlc_pkg::CFG_YELLOW_LENGTH:    yellow_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Advance tick divider, countdown and scan position for one item
  assign tick_inc = tick_q + 8'd1;
  always_comb begin
    tick_d = tick_q;
    secs_d = secs_q;
    scan_d = scan_q;
    if (in_if.req_type == tlc_pkg::REQ_TIME_TICK) begin
      tick_d = tick_inc;
      if (tick_inc == tps_q) begin
        tick_d = '0;
        secs_d = (secs_q == '0) ? top_q : secs_q - 7'd1;
      end
    end else begin
      scan_d = scan_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      secs_q <= tlc_pkg::TOP_RESET;
      scan_q <= '0;
    end else if (in_fire) begin
      tick_q <= tick_d;
      secs_q <= secs_d;
      scan_q <= scan_d;
    end
  end

  // Capture post-update state with the item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_manual_q   <= in_if.manual_mode;
      s1_dir_q      <= in_if.manual_direction;
      s1_scan_req_q <= in_if.req_type;
      s1_secs_q     <= secs_d;
      s1_scan_q     <= scan_d;
    end
  end

  // Decode phase, remaining seconds and the scanned digit
  logic [7:0] t_w, s_w, sy_w;
  logic [6:0] show1, show2;
  logic [1:0] dsel;
  always_comb begin
    t_w   = {1'b0, s1_secs_q};
    s_w   = {1'b0, switch_q};
    sy_w  = s_w + {1'b0, yellow_q};
    out_d = '0;
    out_d.segment_pattern = tlc_pkg::SEG_BLANK;
    dsel  = s1_scan_q + 2'd3;
    if (t_w > sy_w) begin
      out_d.red_one   = 1'b1;
      out_d.green_two = 1'b1;
      show1 = 7'(t_w - s_w - 8'd1);
      show2 = 7'(t_w - sy_w - 8'd1);
    end else if (t_w > s_w) begin
      out_d.red_one    = 1'b1;
      out_d.yellow_two = 1'b1;
      show1 = 7'(t_w - s_w - 8'd1);
      show2 = show1;
    end else if (s1_secs_q >= yellow_q) begin
      out_d.green_one = 1'b1;
      out_d.red_two   = 1'b1;
      show1 = s1_secs_q - yellow_q;
      show2 = s1_secs_q;
    end else begin
      out_d.yellow_one = 1'b1;
      out_d.red_two    = 1'b1;
      show1 = s1_secs_q;
      show2 = s1_secs_q;
    end

    if (s1_manual_q) begin
      out_d.red_one    = s1_dir_q;
      out_d.green_two  = s1_dir_q;
      out_d.yellow_one = 1'b0;
      out_d.green_one  = !s1_dir_q;
      out_d.red_two    = !s1_dir_q;
      out_d.yellow_two = 1'b0;
    end else if (s1_scan_req_q == tlc_pkg::REQ_SCAN_TICK) begin
      out_d.digit_enable = 4'b0001 << dsel;
      case (dsel)
        2'd0:    out_d.segment_pattern = tlc_pkg::seg_of(show1, 1'b1);
        2'd1:    out_d.segment_pattern = tlc_pkg::seg_of(show1, 1'b0);
        2'd2:    out_d.segment_pattern = tlc_pkg::seg_of(show2, 1'b1);
        default: out_d.segment_pattern = tlc_pkg::seg_of(show2, 1'b0);
      endcase
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.red_one         = out_q.red_one;
  assign out_if.yellow_one      = out_q.yellow_one;
  assign out_if.green_one       = out_q.green_one;
  assign out_if.red_two         = out_q.red_two;
  assign out_if.yellow_two      = out_q.yellow_two;
  assign out_if.green_two       = out_q.green_two;
  assign out_if.digit_enable    = out_q.digit_enable;
  assign out_if.segment_pattern = out_q.segment_pattern;

  // Scan ticks step the scan position by one
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_if.req_type == tlc_pkg::REQ_SCAN_TICK
    |=> scan_q == 2'($past(scan_q) + 2'd1))
    else $error("scan position did not advance");

  // Time ticks leave the scan position alone
  a_time_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_if.req_type == tlc_pkg::REQ_TIME_TICK |=> $stable(scan_q))
    else $error("scan position moved on a time tick");

  // A blocked snapshot is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_secs_q))
    else $error("snapshot lost while stalled");

  // At most one digit lit, and blank when none is
  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(out_q.digit_enable) &&
      (out_q.digit_enable != '0 || out_q.segment_pattern == tlc_pkg::SEG_BLANK))
    else $error("bad digit select");

  // Each road shows exactly one lamp
  a_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({out_q.red_one, out_q.yellow_one, out_q.green_one}) &&
      $onehot({out_q.red_two, out_q.yellow_two, out_q.green_two}))
    else $error("lamp set not one-hot");

endmodule

### verif/tb_traffic_light_countdown_controller.sv
// Testbench of the two-road traffic light controller with countdown display.
// Sends time and scan tick items and checks each result item against a predictor of
// lamp phases and countdown digits. Depends on tlc_pkg and the channels in tlc_if.sv.
`timescale 1ns / 100ps

module tb_traffic_light_countdown_controller;
  import tlc_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  tlc_in_if  in_ch ();
  tlc_out_if out_ch ();

  traffic_light_countdown_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Predictor copy of the timing registers and the counters
  logic [7:0] tps_reg;
  logic [6:0] top_reg;
  logic [6:0] switch_reg;
  logic [6:0] yellow_reg;
  logic [7:0] tick_cnt;
  logic [6:0] secs_left;
  logic [1:0] scan_pos;

  tlc_out_t light_due_q [$];
  int       mismatch_count = 0;
  bit       idle_on = 1'b1;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ch.ready <= !(idle_on && $urandom_range(99) < 22);
  end

  // Segment code of one digit of a displayed value, clamped to two digits
  function automatic logic [7:0] seg_digit(int value, bit tens);
    int v;
    v = (value > SHOW_MAX) ? SHOW_MAX : value;
    return SEG_CODE[tens ? v / 10 : v % 10];
  endfunction

  // Advance the counters by one item and build the lamps and digit it shows
  function automatic tlc_out_t advance_light_model(logic req, logic man, logic dir);
    tlc_out_t   r;
    int         t;
    int         s;
    int         y;
    int         show1;
    int         show2;
    logic [5:0] lamps;
    logic [1:0] digit;
    r = '0;
    r.segment_pattern = SEG_BLANK;
    if (req == REQ_TIME_TICK) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == tps_reg) begin
        tick_cnt  = '0;
        secs_left = (secs_left == 7'd0) ? top_reg : secs_left - 7'd1;
      end
    end else begin
      scan_pos = scan_pos + 2'd1;
    end

    // Pick the phase; lamps are red1, yellow1, green1, red2, yellow2, green2
    t = secs_left;
    s = switch_reg;
    y = yellow_reg;
    if (t > s + y) begin
      lamps = 6'b100_001;
      show1 = t - s - 1;
      show2 = t - s - y - 1;
    end else if (t > s) begin
      lamps = 6'b100_010;
      show1 = t - s - 1;
      show2 = show1;
    end else if (t >= y) begin
      lamps = 6'b001_100;
      show1 = t - y;
      show2 = t;
    end else begin
      lamps = 6'b010_100;
      show1 = t;
      show2 = t;
    end

    // Manual mode overrides lamps and blanks the display
    if (man) begin
      lamps = dir ? 6'b100_001 : 6'b001_100;
    end else if (req == REQ_SCAN_TICK) begin
      digit = scan_pos - 2'd1;
      r.digit_enable    = 4'b0001 << digit;
      r.segment_pattern = seg_digit(digit[1] ? show2 : show1, !digit[0]);
    end
    {r.red_one, r.yellow_one, r.green_one, r.red_two, r.yellow_two, r.green_two} = lamps;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tlc_out_t seen;
    tlc_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.red_one, out_ch.yellow_one, out_ch.green_one, out_ch.red_two,
              out_ch.yellow_two, out_ch.green_two, out_ch.digit_enable,
              out_ch.segment_pattern};
      if (light_due_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result item with none outstanding: %p", $time, seen);
        mismatch_count++;
      end else begin
        want = light_due_q.pop_front();
        check_field("red_one", want.red_one, seen.red_one);
        check_field("yellow_one", want.yellow_one, seen.yellow_one);
        check_field("green_one", want.green_one, seen.green_one);
        check_field("red_two", want.red_two, seen.red_two);
        check_field("yellow_two", want.yellow_two, seen.yellow_two);
        check_field("green_two", want.green_two, seen.green_two);
        check_field("digit_enable", want.digit_enable, seen.digit_enable);
        check_field("segment_pattern", want.segment_pattern, seen.segment_pattern);
      end
    end
  end

  // Offer one item, with random gaps ahead of it, and predict it once taken
  task automatic send_item(logic req, logic man, logic dir);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.req_type         <= req;
    in_ch.manual_mode      <= man;
    in_ch.manual_direction <= dir;
    do @(posedge clk_i); while (!in_ch.ready);
    light_due_q.push_back(advance_light_model(req, man, dir));
  endtask

  task automatic send_random(int pct_time);
    send_item(($urandom_range(99) < pct_time) ? REQ_TIME_TICK : REQ_SCAN_TICK,
              $urandom_range(9) == 0, 1'($urandom_range(1)));
  endtask

  // Drop valid and hold until every predicted item has come back
  task automatic wait_results_done();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (light_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TICKS_PER_SECOND: tps_reg    = data;
      CFG_CYCLE_TOP:        top_reg    = data[6:0];
      CFG_SWITCH_POINT:     switch_reg = data[6:0];
      CFG_YELLOW_LENGTH:    yellow_reg = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(logic [7:0] tps, logic [6:0] top, logic [6:0] sw,
                            logic [6:0] yl);
    write_reg(CFG_TICKS_PER_SECOND, tps);
    write_reg(CFG_CYCLE_TOP, {1'b0, top});
    write_reg(CFG_SWITCH_POINT, {1'b0, sw});
    write_reg(CFG_YELLOW_LENGTH, {1'b0, yl});
  endtask

  // Reprogram while idle, run random traffic, then drain
  task automatic run_traffic(logic [7:0] tps, logic [6:0] top, logic [6:0] sw,
                             logic [6:0] yl, int count, int pct_time);
    wait_results_done();
    set_timing(tps, top, sw, yl);
    repeat (count) send_random(pct_time);
    wait_results_done();
  endtask

  // Default registers: all four digits, then one time tick
  task automatic test_reset_defaults();
    repeat (4) send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
    send_item(REQ_TIME_TICK, 1'b0, 1'b0);
  endtask

  // Manual lamps for both directions on both tick kinds
  task automatic test_manual_override();
    send_item(REQ_TIME_TICK, 1'b1, 1'b0);
    send_item(REQ_TIME_TICK, 1'b1, 1'b1);
    send_item(REQ_SCAN_TICK, 1'b1, 1'b1);
    send_item(REQ_SCAN_TICK, 1'b1, 1'b0);
  endtask

  // Walk the countdown through each lamp phase near its reset value
  task automatic test_phase_order();
    wait_results_done();
    // End the current second on the next time tick
    set_timing(tick_cnt + 8'd1, 7'd62, 7'd59, 7'd1);
    send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
    send_item(REQ_TIME_TICK, 1'b0, 1'b0);
    send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
    wait_results_done();
    write_reg(CFG_TICKS_PER_SECOND, 8'd1);
    send_item(REQ_TIME_TICK, 1'b0, 1'b0);
    send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
    // Yellow longer than the countdown: falls through to road 1 yellow
    wait_results_done();
    write_reg(CFG_YELLOW_LENGTH, 8'd97);
    send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
    send_item(REQ_TIME_TICK, 1'b0, 1'b0);
    send_item(REQ_SCAN_TICK, 1'b0, 1'b0);
  endtask

  // Register extremes, clamped display, divider wrap and a tiny reload value
  task automatic test_timing_extremes();
    run_traffic(8'd1, 7'd2, 7'd1, 7'd1, 50, 60);
    idle_on = 1'b0;
    run_traffic(8'd1, 7'd127, 7'd0, 7'd0, 110, 50);
    idle_on = 1'b1;
    run_traffic(8'd255, 7'd99, 7'd98, 7'd97, 40, 50);
    run_traffic(8'd0, 7'd1, 7'd0, 7'd0, 300, 95);
  endtask

  // Consistent random timing, divider set just past the current count
  task automatic test_random_timing();
    logic [6:0] top;
    logic [6:0] sw;
    logic [6:0] yl;
    logic [7:0] tps;
    repeat (3) begin
      wait_results_done();
      top = 7'($urandom_range(3, 99));
      sw  = 7'($urandom_range(1, top - 2));
      yl  = 7'($urandom_range(1, top - 1 - sw));
      tps = (tick_cnt > 8'd240) ? 8'($urandom_range(1, 6))
                                : 8'(tick_cnt + $urandom_range(1, 6));
      run_traffic(tps, top, sw, yl, 40, 50);
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_TICKS_PER_SECOND;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.req_type         = REQ_TIME_TICK;
    in_ch.manual_mode      = 1'b0;
    in_ch.manual_direction = 1'b0;
    out_ch.ready           = 1'b0;
    tps_reg                = TPS_RESET;
    top_reg                = TOP_RESET;
    switch_reg             = SWITCH_RESET;
    yellow_reg             = YELLOW_RESET;
    tick_cnt               = '0;
    secs_left              = TOP_RESET;
    scan_pos               = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_manual_override();
    test_phase_order();
    test_timing_extremes();
    test_random_timing();

    wait_results_done();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && light_due_q.size() == 0) begin
      $display("traffic_light_countdown_controller regression: pass");
    end else begin
      $display("traffic_light_countdown_controller regression: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #2000000;
    $display("traffic_light_countdown_controller regression: fail");
    $finish;
  end

endmodule

### traffic_light_countdown_controller.f
hdl/tlc_pkg.sv
hdl/tlc_if.sv
hdl/traffic_light_countdown_controller.sv
verif/tb_traffic_light_countdown_controller.sv
